// File: rtl/led_matrix_scan_and_input_events_top_macros.svh
// ----------------------------------------------------------------------------
// LED matrix scan assertion macros
// Shared concurrent assertion shorthands for the matrix scan RTL.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_AND_INPUT_EVENTS_TOP_MACROS_SVH
`define LED_MATRIX_SCAN_AND_INPUT_EVENTS_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMSE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LMSE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmse assertion failed");

`endif

// File: rtl/lmse_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan package
// Item and result types, operation and register codes, and fixed constants.
// ----------------------------------------------------------------------------
package lmse_pkg;

  // Operation codes carried in an input item.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DIVIDER   = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_MODE      = 2'd2
  } cfg_idx_t;

  localparam logic [7:0]  ANODE_FIRST      = 8'h80;
  localparam int          NUM_FLAGS        = 6;
  localparam logic [2:0]  LIGHT_FLAG       = 3'd5;
  localparam int          NUM_BUTTONS      = 5;
  localparam logic [15:0] DIVIDER_RESET    = 16'd50;
  localparam logic [9:0]  THRESHOLD_RESET  = 10'd300;
  localparam logic        MODE_RESET       = 1'b1;

  // One input item.
  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] row_number;
    logic [7:0] row_pixels;
    logic [4:0] button_levels;
    logic [9:0] light_level;
    logic [2:0] event_index;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       row_strobe;
    logic [7:0] anode_bits;
    logic [7:0] cathode_bits;
    logic       event_seen;
  } result_t;

  // Per-item control decided by the scan/event logic.
  typedef struct packed {
    logic       strobe;
    logic [7:0] anode;
    logic       seen;
  } scan_info_t;

endpackage

// File: rtl/lmse_image_mem.sv
// ----------------------------------------------------------------------------
// LED matrix image memory
// One-row-per-entry image store with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module lmse_image_mem #(
  parameter int ROWS = 8,
  parameter int AW   = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]      mem [ROWS];
  logic [ROWS-1:0] valid;
  logic [7:0]      rd_q;
  logic            rd_valid;

  // Storage array; a write and a read never come from the same item.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits make never-written rows read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : 8'd0;

endmodule

// File: rtl/lmse_ctrl.sv
// ----------------------------------------------------------------------------
// LED matrix scan and event control
// Configuration registers, tick divider, row scan pointer and event flags.
// ----------------------------------------------------------------------------
module lmse_ctrl #(
  parameter int ROWS = 8,
  parameter int AW   = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_fire,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 item_fire,
  input  lmse_pkg::item_t      item,
  output lmse_pkg::scan_info_t info,
  output logic [AW-1:0]        scan_row
);
  import lmse_pkg::*;

  localparam int SW = $clog2(ROWS + 1);

  logic [15:0]            divider;
  logic [9:0]             threshold;
  logic                   mode;
  logic [15:0]            tick_count;
  logic [15:0]            tick_count_next;
  logic [SW-1:0]          scan_index;
  logic [SW-1:0]          scan_index_next;
  logic [7:0]             anode_select;
  logic [7:0]             anode_select_next;
  logic [NUM_BUTTONS-1:0] last_buttons;
  logic [NUM_BUTTONS-1:0] last_buttons_next;
  logic [9:0]             last_light;
  logic [9:0]             last_light_next;
  logic [NUM_FLAGS-1:0]   event_flags;
  logic [NUM_FLAGS-1:0]   event_flags_next;

  logic                   is_tick;
  logic                   is_read;
  logic [15:0]            count_inc;
  logic                   div_hit;
  logic [15:0]            count_new;
  logic                   advance;
  logic                   sample;
  logic                   wrap;
  logic [SW-1:0]          cur_index;
  logic [7:0]             cur_anode;
  logic signed [11:0]     light_rise;
  logic                   index_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider   <= DIVIDER_RESET;
      threshold <= THRESHOLD_RESET;
      mode      <= MODE_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_DIVIDER:   divider   <= cfg_data;
        CFG_THRESHOLD: threshold <= cfg_data[9:0];
        CFG_MODE:      mode      <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Decide whether this item advances the scan and samples the inputs.
  always_comb begin
    is_tick    = (item.operation == OP_TICK);
    is_read    = (item.operation == OP_READ);
    count_inc  = tick_count + 16'd1;
    div_hit    = (count_inc >= divider);
    count_new  = div_hit ? 16'd0 : count_inc;
    advance    = is_tick && (!mode || div_hit);
    sample     = is_tick && (!mode || (count_new == (divider >> 1)));
    wrap       = (scan_index == SW'(ROWS));
    cur_index  = wrap ? '0 : scan_index;
    cur_anode  = wrap ? ANODE_FIRST : anode_select;
    light_rise = $signed({2'b00, item.light_level}) - $signed({2'b00, last_light});
    index_ok   = (item.event_index <= LIGHT_FLAG);
  end

  assign scan_row    = AW'(cur_index);
  assign info.strobe = advance;
  assign info.anode  = advance ? cur_anode : 8'd0;
  assign info.seen   = is_read && index_ok && event_flags[item.event_index];

  // Next state for the accepted item.
  always_comb begin
    tick_count_next   = tick_count;
    scan_index_next   = scan_index;
    anode_select_next = anode_select;
    last_buttons_next = last_buttons;
    last_light_next   = last_light;
    event_flags_next  = event_flags;
    if (is_tick && mode) begin
      tick_count_next = count_new;
    end
    if (advance) begin
      scan_index_next   = cur_index + SW'(1);
      anode_select_next = cur_anode >> 1;
    end
    if (sample) begin
      event_flags_next[NUM_BUTTONS-1:0] = event_flags[NUM_BUTTONS-1:0]
                                          | (last_buttons & ~item.button_levels);
      if (light_rise >= $signed({2'b00, threshold})) begin
        event_flags_next[LIGHT_FLAG] = 1'b1;
      end
      last_buttons_next = item.button_levels;
      last_light_next   = item.light_level;
    end
    if (is_read && index_ok) begin
      event_flags_next[item.event_index] = 1'b0;
    end
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      scan_index   <= '0;
      anode_select <= ANODE_FIRST;
      last_buttons <= '0;
      last_light   <= '0;
      event_flags  <= '0;
    end else if (item_fire) begin
      tick_count   <= tick_count_next;
      scan_index   <= scan_index_next;
      anode_select <= anode_select_next;
      last_buttons <= last_buttons_next;
      last_light   <= last_light_next;
      event_flags  <= event_flags_next;
    end
  end

endmodule

// File: rtl/led_matrix_scan_and_input_events_top.sv
// Path: an accepted item passes the image memory read stage, then the result register.
// Throughput: one item per cycle while the result receiver keeps up; the image memory
// read stage and the result register form a two-deep pipeline with independent stalls.
// Reset: synchronous, clears scan state, event flags, image valid bits and
// pipeline valids, and loads the configuration defaults. No clearing pass.
// ----------------------------------------------------------------------------
// LED matrix scan and input events top level
// Row-scan controller with image memory, tick divider and latched input events.
// ----------------------------------------------------------------------------
module led_matrix_scan_and_input_events_top #(
  parameter int MATRIX_ROWS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  lmse_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output lmse_pkg::result_t result
);
  import lmse_pkg::*;
  `include "led_matrix_scan_and_input_events_top_macros.svh"

  localparam int AW = $clog2(MATRIX_ROWS);

  logic       item_fire;
  logic       cfg_fire;
  scan_info_t info;
  logic [AW-1:0] scan_row;
  logic       wr_en;
  logic [7:0] rd_data;
  logic       s1_valid;
  scan_info_t s1_info;
  logic       s1_move;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Pipeline handshake: the read stage moves when the result register frees.
  assign s1_move    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_move;
  assign item_fire  = item_valid && item_ready;

  // Image writes outside the matrix are dropped.
  assign wr_en = item_fire && (item.operation == OP_WRITE)
                 && (32'(item.row_number) < MATRIX_ROWS);

  lmse_ctrl #(
    .ROWS (MATRIX_ROWS),
    .AW   (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_fire (item_fire),
    .item      (item),
    .info      (info),
    .scan_row  (scan_row)
  );

  lmse_image_mem #(
    .ROWS (MATRIX_ROWS),
    .AW   (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (AW'(item.row_number)),
    .wr_data (item.row_pixels),
    .rd_en   (item_fire && info.strobe),
    .rd_addr (scan_row),
    .rd_data (rd_data)
  );

  // Read stage: holds the item's control while the memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_info <= info;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.row_strobe   <= s1_info.strobe;
      result.anode_bits   <= s1_info.anode;
      result.cathode_bits <= s1_info.strobe ? rd_data : 8'd0;
      result.event_seen   <= s1_info.seen;
    end
  end

  // A result never carries both a scan strobe and a read flag.
  `LMSE_ASSERT_IMP(a_seen_no_strobe, clk, rst, result_valid && result.event_seen, !result.row_strobe)
  // Without a strobe the drive fields stay zero.
  `LMSE_ASSERT_IMP(a_idle_drive_zero, clk, rst, result_valid && !result.row_strobe, (result.anode_bits == 8'd0) && (result.cathode_bits == 8'd0))
  // The anode drive selects at most one row.
  `LMSE_ASSERT_IMP(a_anode_onehot, clk, rst, result_valid, $onehot0(result.anode_bits))
  // A stalled read stage keeps its item.
  `LMSE_ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !s1_move, s1_valid)

endmodule

// File: dv/lmse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix scan result checker
// Watches the register, item and result channels of the matrix scanner,
// keeps its own copy of the scan and event state, and checks every result
// against the oldest expected one.
// ----------------------------------------------------------------------------
module lmse_checker #(
  parameter int MATRIX_ROWS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              item_valid,
  input  logic              item_ready,
  input  lmse_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  lmse_pkg::result_t result,
  output int                mismatches,
  output int                pending,
  output int                strobes,
  output int                set_reads
);
  import lmse_pkg::*;

  // Register copies.
  logic [15:0] divider;
  logic [9:0]  threshold;
  logic        divided;

  // Scan and event state.
  logic [15:0] tick_cnt;
  logic [3:0]  scan_idx;
  logic [7:0]  anode_sel;
  logic [7:0]  image_mem [0:15];
  logic [4:0]  prev_buttons;
  logic [9:0]  prev_light;
  logic [5:0]  flags;

  result_t expected_scan_results [$];

  // Drive the next row of the image and move the anode one place down.
  function automatic result_t advance_scan();
    result_t r;
    if (scan_idx == MATRIX_ROWS) begin
      scan_idx  = '0;
      anode_sel = ANODE_FIRST;
    end
    r = '0;
    r.row_strobe   = 1'b1;
    r.anode_bits   = anode_sel;
    r.cathode_bits = image_mem[scan_idx];
    anode_sel = anode_sel >> 1;
    scan_idx  = scan_idx + 4'd1;
    return r;
  endfunction

  // Latch button falling edges and a large enough light rise.
  function automatic void sample_inputs(logic [4:0] buttons, logic [9:0] light);
    int rise;
    flags[NUM_BUTTONS-1:0] = flags[NUM_BUTTONS-1:0] | (prev_buttons & ~buttons);
    prev_buttons = buttons;
    rise = int'(light) - int'(prev_light);
    if (rise >= int'(threshold))
      flags[LIGHT_FLAG] = 1'b1;
    prev_light = light;
  endfunction

  // Result of one item, with the state update it causes.
  function automatic result_t scan_item_result(item_t it);
    result_t r;
    r = '0;
    case (it.operation)
      OP_TICK: begin
        if (divided) begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= divider) begin
            r = advance_scan();
            tick_cnt = '0;
          end
          if (tick_cnt == (divider >> 1))
            sample_inputs(it.button_levels, it.light_level);
        end else begin
          r = advance_scan();
          sample_inputs(it.button_levels, it.light_level);
        end
      end
      OP_WRITE: begin
        if (it.row_number < MATRIX_ROWS)
          image_mem[it.row_number] = it.row_pixels;
      end
      OP_READ: begin
        if (it.event_index <= LIGHT_FLAG) begin
          r.event_seen = flags[it.event_index];
          flags[it.event_index] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: result %s mismatch, expected 0x%0h, got 0x%0h",
               $time, field, want, got);
    end
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    strobes    = 0;
    set_reads  = 0;
  end

  // Results are checked before the item of the same edge is predicted:
  // the pipeline never returns a result in the cycle its item goes in.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      divider      = DIVIDER_RESET;
      threshold    = THRESHOLD_RESET;
      divided      = MODE_RESET;
      tick_cnt     = '0;
      scan_idx     = '0;
      anode_sel    = ANODE_FIRST;
      prev_buttons = '0;
      prev_light   = '0;
      flags        = '0;
      for (int i = 0; i < 16; i++)
        image_mem[i] = '0;
      expected_scan_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIVIDER:   divider   = cfg_data;
          CFG_THRESHOLD: threshold = cfg_data[9:0];
          CFG_MODE:      divided   = cfg_data[0];
          default: ;
        endcase
      end

      if (result_valid && result_ready) begin
        if (expected_scan_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got 0x%0h",
                   $time, result);
        end else begin
          want = expected_scan_results.pop_front();
          check_field("row_strobe", 8'(want.row_strobe), 8'(result.row_strobe));
          check_field("anode_bits", want.anode_bits, result.anode_bits);
          check_field("cathode_bits", want.cathode_bits, result.cathode_bits);
          check_field("event_seen", 8'(want.event_seen), 8'(result.event_seen));
          if (result.row_strobe === 1'b1)
            strobes++;
          if (result.event_seen === 1'b1)
            set_reads++;
        end
      end

      if (item_valid && item_ready)
        expected_scan_results.push_back(scan_item_result(item));
    end
    pending = expected_scan_results.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix scan regression bench
// Drives image writes, ticks and flag reads through the scanner under a
// series of register settings, with bursty input and a stalling receiver;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import lmse_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [1:0] CFG_NONE    = 2'd3;
  localparam int         NUM_PHASES  = 12;
  localparam int         PHASE_ITEMS = 112;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       scan_item    = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     scan_result;

  int mismatches;
  int pending;
  int strobes;
  int set_reads;

  int          items_sent  = 0;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          mode_cycles = 0;
  int          stall_left  = 0;
  logic [9:0]  cur_thr     = THRESHOLD_RESET;
  logic [9:0]  last_light  = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  led_matrix_scan_and_input_events_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (scan_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (scan_result)
  );

  lmse_checker scan_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (scan_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (scan_result),
    .mismatches   (mismatches),
    .pending      (pending),
    .strobes      (strobes),
    .set_reads    (set_reads)
  );

  // Receiver: switches between always ready, coin flips, ready when the mode
  // counter is a multiple of four, and bursts of stalls.
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 3);
      mode_cycles = $urandom_range(20, 120);
    end
    mode_cycles--;
    case (stall_mode)
      0: result_ready = 1'b1;
      1: result_ready = 1'($urandom_range(0, 1));
      2: result_ready = (mode_cycles % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          result_ready = 1'b0;
        end else begin
          result_ready = 1'b1;
          if ($urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        end
      end
    endcase
  end

  function automatic item_t make_item(logic [1:0] op, logic [2:0] row, logic [7:0] pix,
                                      logic [4:0] btn, logic [9:0] light, logic [2:0] ev);
    item_t it;
    it.operation     = op;
    it.row_number    = row;
    it.row_pixels    = pix;
    it.button_levels = btn;
    it.light_level   = light;
    it.event_index   = ev;
    return it;
  endfunction

  // Mostly ticks, with writes and reads mixed in; tick light levels often
  // land right at the threshold rise from the last level.
  function automatic item_t random_item();
    item_t it;
    int    pick;
    int    level;
    it   = item_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 58)
      it.operation = OP_TICK;
    else if (pick < 78)
      it.operation = OP_WRITE;
    else if (pick < 97)
      it.operation = OP_READ;
    else
      it.operation = OP_NONE;

    if ($urandom_range(0, 9) < 8)
      it.event_index = 3'($urandom_range(0, 5));
    else
      it.event_index = 3'($urandom_range(6, 7));

    if ($urandom_range(0, 3) == 0)
      it.button_levels = $urandom_range(0, 1) ? 5'h1F : 5'h00;

    case ($urandom_range(0, 3))
      2: begin
        level = int'(last_light) + int'(cur_thr) + int'($urandom_range(0, 2)) - 1;
        if (level > 1023)
          level = 1023;
        if (level < 0)
          level = 0;
        it.light_level = 10'(level);
      end
      3: it.light_level = last_light;
      default: ;
    endcase
    if (it.operation == OP_TICK)
      last_light = it.light_level;
    return it;
  endfunction

  // Send one item; the sender works in bursts and now and then holds off
  // until every result is back.
  task automatic push_item(input item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      if ($urandom_range(0, 29) == 0) begin
        item_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    burst_left--;
    item_valid = 1'b1;
    scan_item  = it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only once the block has drained.
  task automatic configure(input logic [15:0] div, input logic [9:0] thr,
                           input logic mode);
    logic [15:0] noise;
    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    noise = 16'($urandom);
    write_reg(CFG_DIVIDER, div);
    write_reg(CFG_THRESHOLD, {noise[15:10], thr});
    write_reg(CFG_MODE, {noise[14:0], mode});
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_NONE, noise);
    cur_thr = thr;
  endtask

  initial begin
    logic [7:0]  row_art   [8];
    logic [4:0]  tick_btn  [9];
    logic [9:0]  tick_lvl  [9];
    logic [15:0] div;
    logic [9:0]  thr;
    logic        mode;

    row_art  = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h3C, 8'hC3};
    tick_btn = '{5'h1F, 5'h00, 5'h1F, 5'h00, 5'h15, 5'h0A, 5'h1F, 5'h00, 5'h1F};
    tick_lvl = '{10'd0, 10'd1023, 10'd1023, 10'd500, 10'd0, 10'd1023, 10'd1022,
                 10'd0, 10'd300};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Whole image with extreme patterns, reads of the missing flags,
    // the unused operation and one tick that only counts.
    for (int r = 0; r < 8; r++)
      push_item(make_item(OP_WRITE, 3'(r), row_art[r], 5'h1F, 10'h3FF, 3'd7));
    push_item(make_item(OP_READ, 3'd0, 8'h00, 5'h00, 10'd0, 3'd6));
    push_item(make_item(OP_READ, 3'd7, 8'hFF, 5'h1F, 10'h3FF, 3'd7));
    push_item(make_item(OP_NONE, 3'd7, 8'hFF, 5'h1F, 10'h3FF, 3'd7));
    push_item(make_item(OP_TICK, 3'd0, 8'h00, 5'h00, 10'd0, 3'd0));

    // Direct mode with a zero threshold: an unchanged level fires, all
    // buttons fall at once, falls never fire, and the scan wraps.
    configure(DIVIDER_RESET, 10'd0, 1'b0);
    for (int t = 0; t < 9; t++)
      push_item(make_item(OP_TICK, 3'(t), 8'(t), tick_btn[t], tick_lvl[t], 3'(t)));
    push_item(make_item(OP_READ, 3'd0, 8'h00, 5'h00, 10'd0, 3'd0));
    push_item(make_item(OP_READ, 3'd0, 8'h00, 5'h00, 10'd0, 3'd4));
    push_item(make_item(OP_READ, 3'd0, 8'h00, 5'h00, 10'd0, LIGHT_FLAG));
    last_light = 10'd300;

    // Random traffic under a series of register settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:  begin div = 16'd1;     thr = 10'd0;     mode = 1'b1; end
        1:  begin div = 16'd0;     thr = 10'($urandom);  mode = 1'b1; end
        2:  begin div = 16'd2;     thr = 10'd1023;  mode = 1'b1; end
        3:  begin
          div  = 16'($urandom_range(3, 8));
          thr  = 10'($urandom_range(0, 200));
          mode = 1'b1;
        end
        4:  begin div = 16'hFFFF;  thr = 10'd512;   mode = 1'b1; end
        5:  begin div = DIVIDER_RESET; thr = THRESHOLD_RESET; mode = MODE_RESET; end
        6:  begin div = 16'($urandom);  thr = 10'($urandom);  mode = 1'b0; end
        7:  begin
          div  = 16'($urandom_range(1, 16));
          thr  = 10'($urandom);
          mode = 1'b1;
        end
        8:  begin div = 16'($urandom);  thr = 10'd1023;  mode = 1'b0; end
        9:  begin div = 16'd4;     thr = 10'd1;     mode = 1'b1; end
        10: begin
          div  = 16'($urandom_range(1, 12));
          thr  = 10'($urandom);
          mode = 1'b1;
        end
        default: begin div = 16'($urandom); thr = 10'd0; mode = 1'b0; end
      endcase
      configure(div, thr, mode);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_item(random_item());
    end

    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d items over %0d register settings in divided and direct modes,",
             items_sent, NUM_PHASES + 2);
    $display("with %0d row strobes and %0d event reads that found the flag set.",
             strobes, set_reads);
    if (mismatches == 0)
      $display("led_matrix_scan_and_input_events_top regression: pass");
    else
      $display("led_matrix_scan_and_input_events_top regression: fail");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("led_matrix_scan_and_input_events_top regression: fail");
    $finish;
  end

endmodule
